/* hw/rtl/bgc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bgc_pkg
// Shared constants, types and timer helpers of the button gesture classifier.
// ----------------------------------------------------------------------------
package bgc_pkg;

	// Width of the hold and window tick counters.
	localparam int TIMER_BITS = 16;
	// Width of the timeout registers.
	localparam int CFG_W      = 16;
	// Width in which a counter and a timeout are compared.
	localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_MS   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLICK_WINDOW_MS = 1'd1;

	// Reset values of the timeouts, in ticks.
	localparam logic [CFG_W-1:0] DEFAULT_MS_LONG_PRESS    = 16'd1000;
	localparam logic [CFG_W-1:0] DEFAULT_MS_CLICK_PENDING = 16'd250;

	// Byte-wide stream words.
	localparam int DATA_W = 8;

	typedef logic [TIMER_BITS-1:0] tick_cnt_t;

	// One result word, lowest bit first: activity, click, double_click, long_press.
	typedef struct packed {
		logic long_press;
		logic double_click;
		logic click;
		logic activity;
	} gesture_t;

	localparam int GESTURE_W = $bits(gesture_t);

	// Count one tick on a running counter, holding at all ones.
	function automatic tick_cnt_t tick_advance(input tick_cnt_t cnt, input logic running);
		tick_advance = (running && (cnt != {TIMER_BITS{1'b1}})) ? cnt + tick_cnt_t'(1) : cnt;
	endfunction

	// A running counter has expired once it reaches its timeout.
	function automatic logic tick_expired(input tick_cnt_t cnt, input logic running,
			input logic [CFG_W-1:0] timeout);
		logic [CMP_W-1:0] cnt_x;
		logic [CMP_W-1:0] tmo_x;
		cnt_x = CMP_W'(cnt);
		tmo_x = CMP_W'(timeout);
		tick_expired = running && (cnt_x >= tmo_x);
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/button_gesture_classifier_unit.sv */
`default_nettype none
// Each accepted tick word gives its result word on m_tdata through the output
// register. Throughput: one tick word per cycle while s_tready is high; the
// gesture state is updated in the same cycle the word is accepted.
// A skid register behind the output register keeps s_tready high for one
// more word while the output is stalled.
// Reset clears the gesture flags, stops both timers and loads the defaults (1000, 250 ticks).
// ----------------------------------------------------------------------------
// button_gesture_classifier_unit
// Turns a stream of debounced button levels, one word per millisecond tick,
// into click, double-click and long-press events.
// ----------------------------------------------------------------------------
module button_gesture_classifier_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Configuration write port.
	input  wire logic                            cfg_we,
	input  wire logic [bgc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [bgc_pkg::CFG_W-1:0]       cfg_data,
	// Tick stream in.
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [bgc_pkg::DATA_W-1:0]      s_tdata,   // [0] level, [7:1] zero
	// Gesture stream out.
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [bgc_pkg::DATA_W-1:0]           m_tdata    // [0] activity, [1] click,
	                                                        // [2] double_click,
	                                                        // [3] long_press, [7:4] zero
);
	import bgc_pkg::*;

	// Timeout registers.
	logic [CFG_W-1:0] long_press_ms_q;
	logic [CFG_W-1:0] click_window_ms_q;

	// Gesture state.
	logic      held_q, held_long_q, click_waiting_q;
	logic      hold_running_q, window_running_q;
	tick_cnt_t hold_count_q, window_count_q;

	// Next gesture state.
	logic      held_d, held_long_d, click_waiting_d;
	logic      hold_running_d, window_running_d;
	tick_cnt_t hold_count_d, window_count_d;

	// Output register and skid register.
	gesture_t  out_q, skid_q, result;
	logic      out_valid_q, skid_valid_q;

	logic      in_fire, out_fire, level;
	tick_cnt_t hold_adv, window_adv;
	logic      hold_exp, window_exp;

	assign level    = s_tdata[0];
	assign s_tready = !skid_valid_q;
	assign in_fire  = s_tvalid && s_tready;
	assign out_fire = out_valid_q && m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(DATA_W-GESTURE_W){1'b0}}, out_q};

	// Configuration writes. An index beyond the register list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_ms_q   <= DEFAULT_MS_LONG_PRESS;
			click_window_ms_q <= DEFAULT_MS_CLICK_PENDING;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LONG_PRESS_MS:   long_press_ms_q   <= cfg_data;
				REG_CLICK_WINDOW_MS: click_window_ms_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Running counters advance first on every tick; the expiry tests see the
	// advanced counts.
	assign hold_adv   = tick_advance(hold_count_q, hold_running_q);
	assign window_adv = tick_advance(window_count_q, window_running_q);
	assign hold_exp   = tick_expired(hold_adv, hold_running_q, long_press_ms_q);
	assign window_exp = tick_expired(window_adv, window_running_q, click_window_ms_q);

	// Gesture decision for the tick on the input.
	always_comb begin
		held_d           = held_q;
		held_long_d      = held_long_q;
		click_waiting_d  = click_waiting_q;
		hold_running_d   = hold_running_q;
		window_running_d = window_running_q;
		hold_count_d     = hold_adv;
		window_count_d   = window_adv;
		result           = '0;

		if (level) begin
			if (held_long_q) begin
				// Still held after a long press: nothing new to report.
			end else if (held_q) begin
				if (hold_exp) begin
					// Long press. A pending click is flushed in the same word.
					if (click_waiting_q) begin
						click_waiting_d  = 1'b0;
						window_running_d = 1'b0;
						window_count_d   = '0;
						result.click     = 1'b1;
					end
					held_d            = 1'b0;
					held_long_d       = 1'b1;
					hold_running_d    = 1'b0;
					hold_count_d      = '0;
					result.long_press = 1'b1;
					result.activity   = 1'b1;
				end
			end else begin
				// A new press starts the hold timer.
				held_d          = 1'b1;
				hold_running_d  = 1'b1;
				hold_count_d    = '0;
				result.activity = 1'b1;
			end
		end else begin
			if (held_long_q) begin
				// The release after a long press only ends it.
				held_long_d     = 1'b0;
				result.activity = 1'b1;
			end else if (held_q) begin
				held_d         = 1'b0;
				hold_running_d = 1'b0;
				hold_count_d   = '0;
				if (!click_waiting_q) begin
					// First release opens the click window.
					click_waiting_d  = 1'b1;
					window_running_d = 1'b1;
					window_count_d   = '0;
				end else if (!window_exp) begin
					// Second release inside the window.
					click_waiting_d     = 1'b0;
					window_running_d    = 1'b0;
					window_count_d      = '0;
					result.double_click = 1'b1;
				end
				result.activity = 1'b1;
			end else if (click_waiting_q && window_exp) begin
				// The window ran out with no second release.
				click_waiting_d  = 1'b0;
				window_running_d = 1'b0;
				window_count_d   = '0;
				result.click     = 1'b1;
				result.activity  = 1'b1;
			end
		end
	end

	// Gesture state is committed only when a tick word is accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q           <= 1'b0;
			held_long_q      <= 1'b0;
			click_waiting_q  <= 1'b0;
			hold_running_q   <= 1'b0;
			window_running_q <= 1'b0;
			hold_count_q     <= '0;
			window_count_q   <= '0;
		end else if (in_fire) begin
			held_q           <= held_d;
			held_long_q      <= held_long_d;
			click_waiting_q  <= click_waiting_d;
			hold_running_q   <= hold_running_d;
			window_running_q <= window_running_d;
			hold_count_q     <= hold_count_d;
			window_count_q   <= window_count_d;
		end
	end

	// Output valid flags. The skid register fills only when the output
	// register holds a word that is not taken in this cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (in_fire) begin
			if (!out_valid_q || out_fire) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_valid_q  <= skid_valid_q;
			skid_valid_q <= 1'b0;
		end
	end

	// Output payloads, no reset needed.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			if (!out_valid_q || out_fire) begin
				out_q <= result;
			end else begin
				skid_q <= result;
			end
		end else if (out_fire && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	// The hold timer runs exactly while a short press is in progress.
	a_hold_timer_tracks_press: assert property (@(posedge clk) disable iff (!arst_n)
		hold_running_q == held_q)
		else $error("hold timer run state differs from the pressed flag");

	// A short press and a long press are never in progress together.
	a_press_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(held_q && held_long_q))
		else $error("pressed and long-press flags both set");

	// The window timer runs exactly while a click is pending.
	a_window_tracks_click: assert property (@(posedge clk) disable iff (!arst_n)
		window_running_q == click_waiting_q)
		else $error("window timer run state differs from the pending click flag");

	// Every reported event comes with activity.
	a_event_has_activity: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.click || out_q.double_click || out_q.long_press)
			|-> out_q.activity)
		else $error("event reported without activity");

	// The skid register holds a word only behind a full output register.
	a_skid_behind_output: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register full while output register empty");

endmodule
`default_nettype wire

/* sim/button_gesture_classifier_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_gesture_classifier_unit_tb
// Self-checking bench for the button gesture classifier. A queue of tick
// levels feeds a stream driver with random gaps. Every accepted tick word is
// run through a local gesture model that keeps its own copy of the flags,
// timers and timeouts. The expected gesture word is queued, and a stalling
// monitor compares each output word against it. The timeouts are changed
// between phases while the block is idle. The phases include the reset
// defaults, zero timeouts and a range of short timeouts.
// ----------------------------------------------------------------------------
module button_gesture_classifier_unit_tb;

	import bgc_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int MAX_PRINTED    = 40;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [DATA_W-1:0]    s_tdata   = '0;   // [0] level, [7:1] zero
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [DATA_W-1:0]    m_tdata;          // [0] activity, [1] click,
	                                        // [2] double_click, [3] long_press

	button_gesture_classifier_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// Levels still to be sent and gesture words still to be seen.
	bit       tick_levels[$];
	gesture_t pending_gestures[$];

	// When set, neither side inserts gaps or stalls.
	bit quiet = 1'b0;

	int unsigned mismatches   = 0;
	int unsigned ticks_sent   = 0;
	int unsigned words_seen   = 0;
	int unsigned settings_run = 1;
	int unsigned n_clicks     = 0;
	int unsigned n_doubles    = 0;
	int unsigned n_longs      = 0;

	// Local copy of the timeouts, starting from the reset values.
	logic [CFG_W-1:0] long_ms = DEFAULT_MS_LONG_PRESS;
	logic [CFG_W-1:0] win_ms  = DEFAULT_MS_CLICK_PENDING;

	// Local copy of the gesture state.
	bit        is_held      = 1'b0;
	bit        is_held_long = 1'b0;
	bit        click_armed  = 1'b0;
	bit        hold_on      = 1'b0;
	bit        win_on       = 1'b0;
	tick_cnt_t hold_cnt     = '0;
	tick_cnt_t win_cnt      = '0;

	// A running timer has expired once its count reaches the timeout; the
	// comparison is made wide enough for both operands.
	function automatic bit timer_done(input tick_cnt_t cnt, input bit on,
			input logic [CFG_W-1:0] lim);
		return on && (64'(cnt) >= 64'(lim));
	endfunction

	// Advances the gesture state by one tick and returns the gesture word
	// that this tick should produce.
	function automatic gesture_t classify_tick(input bit level);
		gesture_t g;
		g = '0;
		// Running counters advance first and stick at all ones.
		if (hold_on && hold_cnt != '1)
			hold_cnt = hold_cnt + tick_cnt_t'(1);
		if (win_on && win_cnt != '1)
			win_cnt = win_cnt + tick_cnt_t'(1);
		if (level) begin
			if (!is_held_long) begin
				if (is_held) begin
					if (timer_done(hold_cnt, hold_on, long_ms)) begin
						// A waiting click goes out together with the long press.
						if (click_armed) begin
							click_armed = 1'b0;
							win_on      = 1'b0;
							win_cnt     = '0;
							g.click     = 1'b1;
						end
						is_held      = 1'b0;
						is_held_long = 1'b1;
						hold_on      = 1'b0;
						hold_cnt     = '0;
						g.long_press = 1'b1;
						g.activity   = 1'b1;
					end
				end else begin
					is_held    = 1'b1;
					hold_on    = 1'b1;
					hold_cnt   = '0;
					g.activity = 1'b1;
				end
			end
		end else if (is_held_long) begin
			// The release after a long press only ends it.
			is_held_long = 1'b0;
			g.activity   = 1'b1;
		end else if (is_held) begin
			is_held  = 1'b0;
			hold_on  = 1'b0;
			hold_cnt = '0;
			if (!click_armed) begin
				click_armed = 1'b1;
				win_on      = 1'b1;
				win_cnt     = '0;
			end else if (!timer_done(win_cnt, win_on, win_ms)) begin
				click_armed    = 1'b0;
				win_on         = 1'b0;
				win_cnt        = '0;
				g.double_click = 1'b1;
			end
			g.activity = 1'b1;
		end else if (click_armed && timer_done(win_cnt, win_on, win_ms)) begin
			// An expired window on an idle tick gives the single click.
			click_armed = 1'b0;
			win_on      = 1'b0;
			win_cnt     = '0;
			g.click     = 1'b1;
			g.activity  = 1'b1;
		end
		return g;
	endfunction

	// Gap or stall length: mostly none or short, now and then long.
	function automatic int unsigned idle_len();
		int unsigned r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	task automatic note_mismatch(input string what, input int unsigned want,
			input int unsigned seen);
		if (mismatches < MAX_PRINTED)
			$display("MISMATCH at output word %0d, %s: expected %0d, got %0d",
				words_seen, what, want, seen);
		mismatches++;
	endtask

	// ------------------------------------------------------------------------
	// Tick driver. After each word a random gap may follow. The gesture word
	// of a tick is predicted at the edge where the tick is accepted.
	// ------------------------------------------------------------------------
	int unsigned gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		gesture_t g;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			gap_left <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				g = classify_tick(s_tdata[0]);
				pending_gestures.push_back(g);
				ticks_sent++;
				n_clicks  += 32'(g.click);
				n_doubles += 32'(g.double_click);
				n_longs   += 32'(g.long_press);
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					s_tvalid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (tick_levels.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tdata  <= DATA_W'(tick_levels.pop_front());
					gap_left <= idle_len();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Gesture monitor. Each accepted word is checked against the oldest
	// prediction; m_tready drops for random stretches.
	// ------------------------------------------------------------------------
	int unsigned stall_left = 0;

	always @(posedge clk or negedge arst_n) begin
		gesture_t want;
		gesture_t seen;
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen = gesture_t'(m_tdata[GESTURE_W-1:0]);
				if (pending_gestures.size() == 0) begin
					note_mismatch("word with no tick waiting", 0, 32'(m_tdata));
				end else begin
					want = pending_gestures.pop_front();
					if (seen.activity !== want.activity)
						note_mismatch("activity", 32'(want.activity), 32'(seen.activity));
					if (seen.click !== want.click)
						note_mismatch("click", 32'(want.click), 32'(seen.click));
					if (seen.double_click !== want.double_click)
						note_mismatch("double_click", 32'(want.double_click),
							32'(seen.double_click));
					if (seen.long_press !== want.long_press)
						note_mismatch("long_press", 32'(want.long_press),
							32'(seen.long_press));
					if (m_tdata[DATA_W-1:GESTURE_W] !== '0)
						note_mismatch("padding bits", 0, 32'(m_tdata[DATA_W-1:GESTURE_W]));
				end
				words_seen++;
			end
			if (stall_left > 0) begin
				m_tready   <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left <= idle_len();
			end
		end
	end

	// Ends the run if neither side has moved a word for too long.
	int unsigned idle_cycles = 0;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------------

	// Waits until every tick has been sent and answered, then lets the
	// output pipeline settle. Checks happen at the falling edge so that no
	// rising-edge update is still in flight.
	task automatic wait_drained();
		@(negedge clk);
		while (tick_levels.size() != 0 || s_tvalid || pending_gestures.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		if (idx == REG_LONG_PRESS_MS)
			long_ms = value;
		else if (idx == REG_CLICK_WINDOW_MS)
			win_ms = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Sets both timeouts and leaves the bench ready to queue ticks.
	task automatic set_timeouts(input logic [CFG_W-1:0] hold_lim,
			input logic [CFG_W-1:0] win_lim);
		write_reg(REG_LONG_PRESS_MS, hold_lim);
		write_reg(REG_CLICK_WINDOW_MS, win_lim);
		settings_run++;
		@(negedge clk);
	endtask

	task automatic push_run(input bit level, input int unsigned n);
		repeat (n) tick_levels.push_back(level);
	endtask

	// Run lengths cluster around a timeout, where the behavior turns over.
	function automatic int unsigned near_limit(input int unsigned lim);
		int unsigned n;
		case ($urandom_range(0, 5))
			0: n = $urandom_range(1, 3);
			1: n = (lim > 1) ? lim - 1 : 1;
			2: n = lim;
			3: n = lim + 1;
			4: n = lim + 2;
			default: n = $urandom_range(1, 2 * lim + 3);
		endcase
		return (n == 0) ? 1 : n;
	endfunction

	// Mostly press and release pairs with lengths near the timeouts, the
	// rest short bursts of random levels.
	task automatic push_gestures(input int unsigned n_ticks);
		int unsigned start;
		start = tick_levels.size();
		while (tick_levels.size() - start < n_ticks) begin
			if ($urandom_range(0, 4) != 0) begin
				push_run(1'b1, near_limit(32'(long_ms)));
				push_run(1'b0, near_limit(32'(win_ms)));
			end else begin
				repeat ($urandom_range(1, 8)) tick_levels.push_back(1'($urandom_range(0, 1)));
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------------
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset timeouts, left unwritten: a double click, then a single
		// click that waits for the 250-tick window to run out.
		push_run(1'b1, 2); push_run(1'b0, 1); push_run(1'b1, 2); push_run(1'b0, 1);
		push_run(1'b1, 3); push_run(1'b0, 252);
		wait_drained();

		// Directed gestures with a hold limit of 4 and a window of 3.
		set_timeouts(16'd4, 16'd3);
		push_run(1'b0, 1);
		// Single click, given once the window runs out on idle ticks.
		push_run(1'b1, 1); push_run(1'b0, 4);
		// Double click: second release inside the window.
		push_run(1'b1, 1); push_run(1'b0, 1); push_run(1'b1, 1); push_run(1'b0, 1);
		// Late second release: no double click, the click follows when idle.
		push_run(1'b1, 1); push_run(1'b0, 1); push_run(1'b1, 2); push_run(1'b0, 2);
		// Long press that flushes a waiting click, then the release ending it.
		push_run(1'b1, 1); push_run(1'b0, 1); push_run(1'b1, 5); push_run(1'b0, 2);
		wait_drained();

		// Zero timeouts expire on the first tick after the start.
		set_timeouts(16'd0, 16'd0);
		push_gestures(40);
		wait_drained();

		set_timeouts(16'd1, 16'd1);
		quiet = 1'b1;
		push_gestures(40);
		wait_drained();
		quiet = 1'b0;

		set_timeouts(16'd5, 16'd8);
		push_gestures(50);
		wait_drained();

		set_timeouts(16'd12, 16'd3);
		push_gestures(50);
		wait_drained();

		set_timeouts(16'd3, 16'd20);
		push_gestures(40);
		wait_drained();

		set_timeouts(16'd7, 16'd5);
		push_gestures(50);
		wait_drained();

		$display("covered %0d tick words under %0d timeout settings", ticks_sent, settings_run);
		$display("expected events: %0d clicks, %0d double clicks, %0d long presses, %0d errors",
			n_clicks, n_doubles, n_longs, mismatches);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
